// ----- rtl/pcd_pkg.sv -----
// shared field widths for the path conflict detector
package pcd_pkg;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int TIME_W  = 16;
    localparam int AGENT_W = 4;
endpackage

// ----- rtl/pcd_queue.sv -----
// two-entry job queue between loader and checker
module pcd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    logic [W-1:0] r_slot0;
    logic [W-1:0] r_slot1;
    logic [1:0]   r_cnt;

    assign o_data  = r_slot0;
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, i_pop})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_slot0 <= (i_push && r_cnt == 2'd1) ? i_data : r_slot1;
        end else if (i_push && r_cnt == 2'd0) begin
            r_slot0 <= i_data;
        end
        if (i_push && ((r_cnt == 2'd1 && !i_pop) || (r_cnt == 2'd2 && i_pop))) begin
            r_slot1 <= i_data;
        end
    end
endmodule

// ----- rtl/pcd_loader.sv -----
// front end: accepts path points, writes the path store, closes paths and sets
module pcd_loader import pcd_pkg::*; #(
    parameter int MAX_AGENTS = 16,
    parameter int MAX_STEPS  = 64,
    parameter int GRID_SIDE  = 64,
    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1,
    localparam int CW = $clog2(MAX_AGENTS + 1),
    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
    localparam int LW = $clog2(MAX_STEPS + 1),
    localparam int GW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [TIME_W-1:0] i_arrival_time,
    input  logic              i_path_end,
    input  logic              i_set_end,
    input  logic              i_q_full,
    input  logic              i_done,
    output logic              o_cell_we,
    output logic [AW-1:0]     o_cell_agent,
    output logic [SW-1:0]     o_cell_step,
    output logic [2*GW-1:0]   o_cell_data,
    output logic              o_len_we,
    output logic [AW-1:0]     o_len_agent,
    output logic [LW-1:0]     o_len_data,
    output logic [TIME_W-1:0] o_goal_data,
    output logic              o_job_push,
    output logic [CW-1:0]     o_job_count,
    output logic              o_job_ovf
);
    logic [CW-1:0] r_agent_cnt, n_agent_cnt;
    logic [LW-1:0] r_step_cnt, n_step_cnt;
    logic          r_ovf, n_ovf;
    logic          r_busy;
    logic          acc;
    logic [GW-1:0] row_s, col_s;

    assign o_in_stall = r_busy || i_q_full;
    assign acc        = i_in_valid && !o_in_stall;

    // clamp to the grid
    assign row_s = (32'(i_cell_row) > GRID_SIDE - 1) ? GW'(GRID_SIDE - 1) : GW'(i_cell_row);
    assign col_s = (32'(i_cell_col) > GRID_SIDE - 1) ? GW'(GRID_SIDE - 1) : GW'(i_cell_col);

    always_comb begin
        n_agent_cnt  = r_agent_cnt;
        n_step_cnt   = r_step_cnt;
        n_ovf        = r_ovf;
        o_cell_we    = 1'b0;
        o_len_we     = 1'b0;
        o_cell_agent = r_agent_cnt[AW-1:0];
        o_len_agent  = r_agent_cnt[AW-1:0];
        o_cell_step  = r_step_cnt[SW-1:0];
        o_cell_data  = {row_s, col_s};
        o_goal_data  = i_arrival_time;
        o_len_data   = r_step_cnt;
        if (acc) begin
            if (32'(r_agent_cnt) >= MAX_AGENTS) begin
                n_ovf = 1'b1;
            end else begin
                if (32'(r_step_cnt) >= MAX_STEPS) begin
                    n_ovf = 1'b1;
                end else begin
                    o_cell_we  = 1'b1;
                    n_step_cnt = r_step_cnt + LW'(1);
                end
                if ((i_path_end || i_set_end) && n_step_cnt != '0) begin
                    o_len_we    = 1'b1;
                    o_len_data  = n_step_cnt;
                    n_agent_cnt = r_agent_cnt + CW'(1);
                    n_step_cnt  = '0;
                end
            end
        end
        o_job_push  = acc && i_set_end;
        o_job_count = n_agent_cnt;
        o_job_ovf   = n_ovf;
        if (o_job_push) begin
            n_agent_cnt = '0;
            n_step_cnt  = '0;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent_cnt <= '0;
            r_step_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_agent_cnt <= n_agent_cnt;
            r_step_cnt  <= n_step_cnt;
            r_ovf       <= n_ovf;
            if (o_job_push) begin
                r_busy <= 1'b1;
            end else if (i_done) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/pcd_checker.sv -----
// back end: path store and the sequencer that walks vertex, swap and goal checks
module pcd_checker import pcd_pkg::*; #(
    parameter int MAX_AGENTS = 16,
    parameter int MAX_STEPS  = 64,
    parameter int GRID_SIDE  = 64,
    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1,
    localparam int CW = $clog2(MAX_AGENTS + 1),
    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
    localparam int LW = $clog2(MAX_STEPS + 1),
    localparam int GW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1,
    localparam int DEPTH = MAX_AGENTS * MAX_STEPS,
    localparam int MW = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cell_we,
    input  logic [AW-1:0]      i_cell_agent,
    input  logic [SW-1:0]      i_cell_step,
    input  logic [2*GW-1:0]    i_cell_data,
    input  logic               i_len_we,
    input  logic [AW-1:0]      i_len_agent,
    input  logic [LW-1:0]      i_len_data,
    input  logic [TIME_W-1:0]  i_goal_data,
    input  logic               i_q_empty,
    input  logic [CW-1:0]      i_job_count,
    input  logic               i_job_ovf,
    output logic               o_q_pop,
    output logic               o_done,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_conflict_found,
    output logic [AGENT_W-1:0] o_first_agent,
    output logic [AGENT_W-1:0] o_second_agent,
    output logic               o_overflow_error
);
    typedef enum logic [4:0] {
        S_IDLE, V_A, V_A2, V_T, V_B, V_B2, V_C,
        W_A, W_A2, W_T, W_T2, W_B, W_B2, W_C,
        G_U, G_U2, G_U3, G_V, G_V2, G_T, G_T2, S_RES
    } t_state;

    logic [2*GW-1:0]          cmem [DEPTH];
    logic [LW+TIME_W-1:0]     lmem [MAX_AGENTS];
    logic [2*GW-1:0]          r_q0, r_q1;
    logic [LW+TIME_W-1:0]     r_lq;
    logic [MW-1:0]            c_addr0, c_addr1;
    logic [AW-1:0]            l_addr;
    logic [LW-1:0]            lq_len;
    logic [TIME_W-1:0]        lq_goal;

    t_state            r_state;
    logic [CW-1:0]     r_n, r_u, r_v;
    logic [LW-1:0]     r_t, r_lu, r_lv;
    logic [TIME_W-1:0] r_g;
    logic [2*GW-1:0]   r_ca, r_cb;
    logic              r_ovf, r_found;
    logic [CW-1:0]     r_fa, r_sa;

    function automatic logic [MW-1:0] cidx(input logic [CW-1:0] ag, input logic [LW-1:0] t);
        cidx = MW'(int'(ag) * MAX_STEPS + int'(t));
    endfunction

    assign lq_len  = r_lq[LW+TIME_W-1:TIME_W];
    assign lq_goal = r_lq[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cell_we) begin
            cmem[MW'(int'(i_cell_agent) * MAX_STEPS + int'(i_cell_step))] <= i_cell_data;
        end
        r_q0 <= cmem[c_addr0];
        r_q1 <= cmem[c_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            lmem[i_len_agent] <= {i_len_data, i_goal_data};
        end
        r_lq <= lmem[l_addr];
    end

    always_comb begin
        c_addr0 = '0;
        c_addr1 = '0;
        l_addr  = '0;
        unique case (r_state)
            V_A, W_A, G_U: l_addr = r_u[AW-1:0];
            V_B, W_B, G_V: l_addr = r_v[AW-1:0];
            V_B2: begin
                c_addr0 = cidx(r_v, r_t);
                c_addr1 = cidx(r_u, r_t);
            end
            W_T: begin
                c_addr0 = cidx(r_u, r_t);
                c_addr1 = cidx(r_u, r_t - LW'(1));
            end
            W_B2: begin
                c_addr0 = cidx(r_v, r_t - LW'(1));
                c_addr1 = cidx(r_v, r_t);
            end
            G_U2: c_addr0 = cidx(r_u, lq_len - LW'(1));
            G_T:  c_addr0 = cidx(r_v, r_t);
            default: ;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_done  = (r_state == S_RES) && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !o_done) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (!i_q_empty) begin
                    r_n     <= i_job_count;
                    r_ovf   <= i_job_ovf;
                    r_found <= 1'b0;
                    r_u     <= '0;
                    r_state <= (i_job_count == '0) ? S_RES : V_A;
                end
                // vertex pass
                V_A: r_state <= V_A2;
                V_A2: begin
                    r_lu    <= lq_len;
                    r_t     <= '0;
                    r_state <= V_T;
                end
                V_T: if (r_t == r_lu) begin
                    if (r_u + CW'(1) == r_n) begin
                        r_u     <= '0;
                        r_state <= W_A;
                    end else begin
                        r_u     <= r_u + CW'(1);
                        r_state <= V_A;
                    end
                end else begin
                    r_v     <= '0;
                    r_state <= V_B;
                end
                V_B: if (r_v == r_u) begin
                    r_t     <= r_t + LW'(1);
                    r_state <= V_T;
                end else begin
                    r_state <= V_B2;
                end
                V_B2: if (r_t < lq_len) begin
                    r_state <= V_C;
                end else begin
                    r_v     <= r_v + CW'(1);
                    r_state <= V_B;
                end
                V_C: if (r_q0 == r_q1) begin
                    r_found <= 1'b1;
                    r_fa    <= r_v;
                    r_sa    <= r_u;
                    r_state <= S_RES;
                end else begin
                    r_v     <= r_v + CW'(1);
                    r_state <= V_B;
                end
                // swap pass
                W_A: r_state <= W_A2;
                W_A2: begin
                    r_lu    <= lq_len;
                    r_t     <= LW'(1);
                    r_state <= W_T;
                end
                W_T: if (r_t >= r_lu) begin
                    if (r_u + CW'(1) == r_n) begin
                        r_u     <= '0;
                        r_state <= G_U;
                    end else begin
                        r_u     <= r_u + CW'(1);
                        r_state <= W_A;
                    end
                end else begin
                    r_state <= W_T2;
                end
                W_T2: begin
                    r_ca    <= r_q0;
                    r_cb    <= r_q1;
                    r_v     <= '0;
                    r_state <= W_B;
                end
                W_B: if (r_v == r_n) begin
                    r_t     <= r_t + LW'(1);
                    r_state <= W_T;
                end else if (r_v == r_u) begin
                    r_v <= r_v + CW'(1);
                end else begin
                    r_state <= W_B2;
                end
                W_B2: if (r_t < lq_len) begin
                    r_state <= W_C;
                end else begin
                    r_v     <= r_v + CW'(1);
                    r_state <= W_B;
                end
                W_C: if (r_q0 == r_ca && r_q1 == r_cb) begin
                    r_found <= 1'b1;
                    r_fa    <= r_v;
                    r_sa    <= r_u;
                    r_state <= S_RES;
                end else begin
                    r_v     <= r_v + CW'(1);
                    r_state <= W_B;
                end
                // goal pass
                G_U: r_state <= G_U2;
                G_U2: begin
                    r_g     <= lq_goal;
                    r_state <= G_U3;
                end
                G_U3: begin
                    r_ca    <= r_q0;
                    r_v     <= '0;
                    r_state <= G_V;
                end
                G_V: if (r_v == r_n) begin
                    if (r_u + CW'(1) == r_n) begin
                        r_state <= S_RES;
                    end else begin
                        r_u     <= r_u + CW'(1);
                        r_state <= G_U;
                    end
                end else if (r_v == r_u) begin
                    r_v <= r_v + CW'(1);
                end else begin
                    r_state <= G_V2;
                end
                G_V2: if (32'(r_g) < 32'(lq_len)) begin
                    r_lv    <= lq_len;
                    r_t     <= LW'(r_g);
                    r_state <= G_T;
                end else begin
                    r_v     <= r_v + CW'(1);
                    r_state <= G_V;
                end
                G_T: if (r_t == r_lv) begin
                    r_v     <= r_v + CW'(1);
                    r_state <= G_V;
                end else begin
                    r_state <= G_T2;
                end
                G_T2: if (r_q0 == r_ca) begin
                    r_found <= 1'b1;
                    r_fa    <= r_u;
                    r_sa    <= r_v;
                    r_state <= S_RES;
                end else begin
                    r_t     <= r_t + LW'(1);
                    r_state <= G_T;
                end
                S_RES: if (!o_out_valid || !i_out_stall) begin
                    o_out_valid      <= 1'b1;
                    o_conflict_found <= r_found;
                    o_first_agent    <= r_found ? AGENT_W'(32'(r_fa)) : '0;
                    o_second_agent   <= r_found ? AGENT_W'(32'(r_sa)) : '0;
                    o_overflow_error <= r_ovf;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/path_conflict_detector_top.sv -----
// top level of the multi-agent path conflict detector
// walk after the set-end beat: V_B, V_B2, V_C per vertex pair, W_B, W_B2, W_C per
// swap pair, G_T, G_T2 per goal point, plus the per-agent and per-step states
// throughput: one point beat per cycle while loading; input stalls from set end
// until the result is registered; the walk over the path store sets the figure
// reset: synchronous active low, clears counters, queue and sequencer state
module path_conflict_detector_top import pcd_pkg::*; #(
    parameter int MAX_AGENTS = 16,
    parameter int MAX_STEPS  = 64,
    parameter int GRID_SIDE  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ROW_W-1:0]   i_cell_row,
    input  logic [COL_W-1:0]   i_cell_col,
    input  logic [TIME_W-1:0]  i_arrival_time,
    input  logic               i_path_end,
    input  logic               i_set_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_conflict_found,
    output logic [AGENT_W-1:0] o_first_agent,
    output logic [AGENT_W-1:0] o_second_agent,
    output logic               o_overflow_error
);
    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW = $clog2(MAX_AGENTS + 1);
    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int GW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;

    // path store write port from the loader
    logic              cell_we;
    logic [AW-1:0]     cell_agent;
    logic [SW-1:0]     cell_step;
    logic [2*GW-1:0]   cell_data;
    logic              len_we;
    logic [AW-1:0]     len_agent;
    logic [LW-1:0]     len_data;
    logic [TIME_W-1:0] goal_data;

    // job beat: agent count and overflow of a closed set
    logic              job_push, job_pop, q_empty, q_full, done;
    logic [CW-1:0]     job_count, q_count;
    logic              job_ovf, q_ovf;

    pcd_loader #(
        .MAX_AGENTS(MAX_AGENTS), .MAX_STEPS(MAX_STEPS), .GRID_SIDE(GRID_SIDE)
    ) u_loader (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_cell_row, .i_cell_col, .i_arrival_time, .i_path_end, .i_set_end,
        .i_q_full(q_full), .i_done(done),
        .o_cell_we(cell_we), .o_cell_agent(cell_agent), .o_cell_step(cell_step),
        .o_cell_data(cell_data), .o_len_we(len_we), .o_len_agent(len_agent),
        .o_len_data(len_data), .o_goal_data(goal_data),
        .o_job_push(job_push), .o_job_count(job_count), .o_job_ovf(job_ovf)
    );

    pcd_queue #(.W(CW + 1)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(job_push), .i_data({job_count, job_ovf}),
        .i_pop(job_pop), .o_data({q_count, q_ovf}),
        .o_empty(q_empty), .o_full(q_full)
    );

    pcd_checker #(
        .MAX_AGENTS(MAX_AGENTS), .MAX_STEPS(MAX_STEPS), .GRID_SIDE(GRID_SIDE)
    ) u_checker (
        .i_clk, .i_rst_n,
        .i_cell_we(cell_we), .i_cell_agent(cell_agent), .i_cell_step(cell_step),
        .i_cell_data(cell_data), .i_len_we(len_we), .i_len_agent(len_agent),
        .i_len_data(len_data), .i_goal_data(goal_data),
        .i_q_empty(q_empty), .i_job_count(q_count), .i_job_ovf(q_ovf),
        .o_q_pop(job_pop), .o_done(done),
        .o_out_valid, .i_out_stall,
        .o_conflict_found, .o_first_agent, .o_second_agent, .o_overflow_error
    );
endmodule
